/* rtl/core/blake2s_keyed_hash_unit_assert.svh */
// Assertion macros shared by the hash unit RTL.
`ifndef BLAKE2S_KEYED_HASH_UNIT_ASSERT_SVH
`define BLAKE2S_KEYED_HASH_UNIT_ASSERT_SVH

// Assert that an implication holds at every clock edge out of reset.
`define B2S_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition leads to another one in the next cycle.
`define B2S_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/b2s_pkg.sv */
// Package with the BLAKE2s constants, tables and sequencer types.
package b2s_pkg;

    typedef logic [31:0] word_t;

    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_LO     = 3'd1;
    localparam logic [2:0] CFG_KEY_MIDLO  = 3'd2;
    localparam logic [2:0] CFG_KEY_MIDHI  = 3'd3;
    localparam logic [2:0] CFG_KEY_HI     = 3'd4;

    localparam logic [31:0] PARAM_BASE = 32'h0101_0020;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_MIX   = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    function automatic word_t iv_word(input logic [2:0] i);
        word_t w;
        case (i)
            3'd0: w = 32'h6A09E667;
            3'd1: w = 32'hBB67AE85;
            3'd2: w = 32'h3C6EF372;
            3'd3: w = 32'hA54FF53A;
            3'd4: w = 32'h510E527F;
            3'd5: w = 32'h9B05688C;
            3'd6: w = 32'h1F83D9AB;
            default: w = 32'h5BE0CD19;
        endcase
        return w;
    endfunction

    // Message schedule: row r, slot s (0..15) gives the word index.
    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'hFEDCBA9876543210;
            4'd1: row = 64'h357B20C16DF984AE;
            4'd2: row = 64'h491763EADF250C8B;
            4'd3: row = 64'h8F04A562EBCD1397;
            4'd4: row = 64'hD386CB1EFA427509;
            4'd5: row = 64'h91EF57D438B0A6C2;
            4'd6: row = 64'hB8293670A4DEF15C;
            4'd7: row = 64'hA2684F05931CE7BD;
            4'd8: row = 64'h5A417D2C803B9EF6;
            default: row = 64'h0DC3E9BF5167482A;
        endcase
        return row[{s, 2'b00} +: 4];
    endfunction

    function automatic word_t rotr(input word_t x, input logic [4:0] n);
        return (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic word_t byte_mask(input logic [5:0] n);
        word_t m;
        case (n)
            6'd0: m = 32'h0000_0000;
            6'd1: m = 32'h0000_00FF;
            6'd2: m = 32'h0000_FFFF;
            6'd3: m = 32'h00FF_FFFF;
            default: m = ALL_ONES;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/blake2s_keyed_hash_unit.sv */
// BLAKE2s-256 keyed hash unit with a shared quarter-round datapath.
// The unit hashes a message streamed as little-endian 32-bit beats and returns the
// 32-byte digest as eight beats. One G half-step (add, xor, rotate on one column or
// diagonal) is done per cycle by a single shared unit; a compression runs the init
// state, the mix state for ten rounds and the fold state. A block is compressed
// only when the first word of the next block arrives or at the end of the message;
// other beats do not stall the input. A beat that opens a new block keeps the input
// stalled for one compression, and a last beat that opens a new block costs two
// compressions before the digest. The key registers are sampled at the first beat
// of each message. After the last beat, eight digest beats follow and the unit takes
// no input until the last of them has been accepted.
module blake2s_keyed_hash_unit
    import b2s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero pad
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero pad
    output logic        m_tlast,   // last_word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    `include "blake2s_keyed_hash_unit_assert.svh"

    state_t      state_reg, state_next;
    logic [5:0]  klen_reg;
    logic [63:0] key_reg [4];
    word_t       h_reg [8];
    word_t       v_reg [16];
    word_t       m_reg [16];
    logic [63:0] cnt_reg;
    logic [6:0]  fill_reg;
    logic        inmsg_reg;
    logic        final_reg;      // the last beat of the message has been taken
    logic        pend_reg;       // a word waits to be written after compression
    word_t       pend_word_reg;
    logic [2:0]  pend_cnt_reg;
    logic [3:0]  round_reg;
    logic [3:0]  step_reg;       // 8 G calls x 2 halves
    logic [2:0]  idx_reg;

    // Shared G half-step datapath.
    logic [1:0]  col;
    logic [3:0]  ia, ib, ic, id;
    word_t       a0, b0, c0, d0, mx, a1, b1, c1, d1;
    logic [5:0]  klen_c;

    assign klen_c = (klen_reg > 6'd32) ? 6'd32 : klen_reg;

    always_comb begin
        col = step_reg[2:1];
        if (!step_reg[3]) begin
            ia = {2'b00, col};
            ib = {2'b01, col};
            ic = {2'b10, col};
            id = {2'b11, col};
        end else begin
            ia = {2'b00, col};
            ib = {2'b01, col + 2'd1};
            ic = {2'b10, col + 2'd2};
            id = {2'b11, col + 2'd3};
        end
        a0 = v_reg[ia];
        b0 = v_reg[ib];
        c0 = v_reg[ic];
        d0 = v_reg[id];
        mx = m_reg[sigma(round_reg, {step_reg[3:1], step_reg[0]})];
        a1 = a0 + b0 + mx;
        d1 = rotr(d0 ^ a1, step_reg[0] ? 5'd8 : 5'd16);
        c1 = c0 + d1;
        b1 = rotr(b0 ^ c1, step_reg[0] ? 5'd7 : 5'd12);
    end

    logic       s_fire, m_fire;
    logic [2:0] in_cnt;
    logic [6:0] cur_fill;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign in_cnt    = (!s_tlast || s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign cur_fill  = inmsg_reg ? fill_reg : ((klen_c != 6'd0) ? 7'd64 : 7'd0);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {5'd0, idx_reg, h_reg[idx_reg]};
    assign m_tlast   = (idx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) begin
                if (cur_fill == 7'd64 && in_cnt != 3'd0)
                    state_next = ST_INIT;
                else if (s_tlast)
                    state_next = ST_INIT;
            end
            ST_INIT: state_next = ST_MIX;
            ST_MIX:  if (round_reg == 4'd9 && step_reg == 4'd15) state_next = ST_FOLD;
            ST_FOLD: state_next = (final_reg && !pend_reg) ? ST_OUT :
                                  (pend_reg ? ST_IDLE : ST_IDLE);
            ST_OUT:  if (m_fire && idx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        // A full buffer plus a last word needs a final pass afterwards.
        if (state_reg == ST_FOLD && pend_reg && final_reg) state_next = ST_INIT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            klen_reg  <= '0;
            for (int k = 0; k < 4; k++) key_reg[k] <= '0;
            inmsg_reg <= 1'b0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            final_reg <= 1'b0;
            round_reg <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
            for (int k = 0; k < 8; k++) h_reg[k] <= '0;
            for (int k = 0; k < 16; k++) m_reg[k] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KEY_LENGTH: klen_reg <= cfg_data[5:0];
                    CFG_KEY_LO:     key_reg[0] <= cfg_data;
                    CFG_KEY_MIDLO:  key_reg[1] <= cfg_data;
                    CFG_KEY_MIDHI:  key_reg[2] <= cfg_data;
                    CFG_KEY_HI:     key_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: if (s_fire) begin
                    logic [6:0] f;
                    logic       flush;
                    word_t      din;
                    f     = cur_fill;
                    flush = (f == 7'd64) && (in_cnt != 3'd0);
                    din   = s_tdata[31:0] & byte_mask({3'd0, in_cnt});
                    if (!inmsg_reg) begin
                        for (int k = 0; k < 8; k++)
                            h_reg[k] <= iv_word(3'(k)) ^
                                ((k == 0) ? (PARAM_BASE | {18'd0, klen_c, 8'd0}) : 32'd0);
                        inmsg_reg <= 1'b1;
                    end
                    // Words past the fill point are always zero, so a new message
                    // reloads the whole buffer and a data word lands in one slot.
                    for (int k = 0; k < 16; k++) begin
                        if (!flush && in_cnt != 3'd0 && 4'(k) == f[5:2])
                            m_reg[k] <= din;
                        else if (!inmsg_reg && k < 8)
                            m_reg[k] <= key_reg[k[2:1]][{k[0], 5'd0} +: 32] &
                                byte_mask((klen_c > 6'(4*k)) ? klen_c - 6'(4*k) : 6'd0);
                        else if (!inmsg_reg)
                            m_reg[k] <= '0;
                    end
                    final_reg <= s_tlast;
                    pend_reg  <= flush;
                    if (flush) begin
                        pend_word_reg <= din;
                        pend_cnt_reg  <= in_cnt;
                    end
                    fill_reg <= flush ? f : f + 7'(in_cnt);
                    if (!inmsg_reg)
                        cnt_reg <= (s_tlast && !flush) ? 64'(f + 7'(in_cnt)) : 64'd0;
                    else if (s_tlast && !flush)
                        cnt_reg <= cnt_reg + 64'(f + 7'(in_cnt));
                end
                ST_INIT: begin
                    round_reg <= '0;
                    step_reg  <= '0;
                    if (pend_reg) cnt_reg <= cnt_reg + 64'd64;
                end
                ST_MIX: begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15) round_reg <= round_reg + 4'd1;
                end
                ST_FOLD: begin
                    for (int k = 0; k < 8; k++) h_reg[k] <= h_reg[k] ^ v_reg[k] ^ v_reg[k+8];
                    idx_reg <= '0;
                    if (pend_reg) begin
                        m_reg[0] <= pend_word_reg;
                        for (int k = 1; k < 16; k++) m_reg[k] <= '0;
                        fill_reg <= 7'(pend_cnt_reg);
                        pend_reg <= 1'b0;
                        if (final_reg) cnt_reg <= cnt_reg + 64'(pend_cnt_reg);
                    end else if (!final_reg) begin
                        fill_reg <= fill_reg;
                    end
                end
                ST_OUT: if (m_fire) begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        inmsg_reg <= 1'b0;
                        fill_reg  <= '0;
                        final_reg <= 1'b0;
                        for (int k = 0; k < 8; k++) h_reg[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working vector: loaded in ST_INIT, one G half-step per ST_MIX cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_INIT) begin
            for (int k = 0; k < 8; k++) begin
                v_reg[k]   <= h_reg[k];
                v_reg[k+8] <= iv_word(3'(k));
            end
            v_reg[12] <= iv_word(3'd4) ^ (pend_reg ? cnt_reg[31:0] + 32'd64 : cnt_reg[31:0]);
            v_reg[13] <= iv_word(3'd5) ^ (pend_reg ? 32'((cnt_reg + 64'd64) >> 32)
                                                   : cnt_reg[63:32]);
            v_reg[14] <= iv_word(3'd6) ^ ((final_reg && !pend_reg) ? ALL_ONES : 32'd0);
        end else if (state_reg == ST_MIX) begin
            v_reg[ia] <= a1;
            v_reg[ib] <= b1;
            v_reg[ic] <= c1;
            v_reg[id] <= d1;
        end
    end

    `B2S_ASSERT_IMPL(a_no_out_when_ready, aclk, aresetn, s_tready, !m_tvalid)
    `B2S_ASSERT_NEXT(a_out_done, aclk, aresetn, m_fire && m_tlast, s_tready)
    `B2S_ASSERT_IMPL(a_fill_range, aclk, aresetn, 1'b1, fill_reg <= 7'd64)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the BLAKE2s-256 keyed hash unit.
module tb_top;
    import b2s_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and the three channels of the unit.
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // data_word[31:0], byte_count[34:32], zero pad
    logic        s_tlast;   // last_item
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // digest_word[31:0], word_index[34:32], zero pad
    logic        m_tlast;   // last_word
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // Marks the beat on the input bus whose digest is a known answer from the table.
    logic        beat_is_kat;

    blake2s_keyed_hash_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock period.
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Hash predictor. It keeps its own copy of the key registers and of
    // the chaining state and reproduces the unit one input beat at a time.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        final_word;
    } digest_beat_t;

    localparam logic [31:0] BLAKE_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Message word order for each of the ten rounds.
    localparam int MSG_ORDER [10][16] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
        '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
        '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
        '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
        '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
        '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
        '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
        '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
        '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
    };

    // Digest of the empty message without a key, as little-endian words.
    localparam logic [31:0] EMPTY_DIGEST [8] = '{
        32'h307A2169, 32'h94809079, 32'hD02111E1, 32'h7C4A3542,
        32'h48B6551F, 32'h1EA5A12C, 32'hFD0D251B, 32'hF9EED01E
    };

    logic [5:0]  model_key_len;
    logic [63:0] model_key [4];
    logic [31:0] hash_state [8];
    logic [63:0] bytes_hashed;
    logic [31:0] block_words [16];
    int unsigned block_fill;
    bit          msg_open;
    logic [31:0] work [16];

    digest_beat_t digest_q [$];
    int           fail_count;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] low_bytes(input int unsigned n);
        return (n >= 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * n)) - 32'h1);
    endfunction

    // Message word used in slot s of round r.
    function automatic logic [31:0] msg_word(input int r, input int s);
        return block_words[MSG_ORDER[r][s]];
    endfunction

    function automatic void quarter_round(input int a, input int b, input int c, input int d,
                                          input logic [31:0] x, input logic [31:0] y);
        work[a] = work[a] + work[b] + x;
        work[d] = ror32(work[d] ^ work[a], 16);
        work[c] = work[c] + work[d];
        work[b] = ror32(work[b] ^ work[c], 12);
        work[a] = work[a] + work[b] + y;
        work[d] = ror32(work[d] ^ work[a], 8);
        work[c] = work[c] + work[d];
        work[b] = ror32(work[b] ^ work[c], 7);
    endfunction

    function automatic void compress_block(input bit is_final);
        for (int i = 0; i < 8; i++) begin
            work[i]     = hash_state[i];
            work[i + 8] = BLAKE_IV[i];
        end
        work[12] ^= bytes_hashed[31:0];
        work[13] ^= bytes_hashed[63:32];
        if (is_final)
            work[14] = ~work[14];
        for (int r = 0; r < 10; r++) begin
            quarter_round(0, 4,  8, 12, msg_word(r, 0),  msg_word(r, 1));
            quarter_round(1, 5,  9, 13, msg_word(r, 2),  msg_word(r, 3));
            quarter_round(2, 6, 10, 14, msg_word(r, 4),  msg_word(r, 5));
            quarter_round(3, 7, 11, 15, msg_word(r, 6),  msg_word(r, 7));
            quarter_round(0, 5, 10, 15, msg_word(r, 8),  msg_word(r, 9));
            quarter_round(1, 6, 11, 12, msg_word(r, 10), msg_word(r, 11));
            quarter_round(2, 7,  8, 13, msg_word(r, 12), msg_word(r, 13));
            quarter_round(3, 4,  9, 14, msg_word(r, 14), msg_word(r, 15));
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] ^= work[i] ^ work[i + 8];
    endfunction

    function automatic void clear_block();
        for (int i = 0; i < 16; i++)
            block_words[i] = '0;
        block_fill = 0;
    endfunction

    // First beat of a message: load the IV with the parameter word and, if
    // a key is set, pre-load the key block. Key lengths above 32 clamp to 32.
    function automatic void open_message();
        int unsigned klen;
        int unsigned valid;
        klen = (model_key_len > 6'd32) ? 32 : model_key_len;
        for (int i = 0; i < 8; i++)
            hash_state[i] = BLAKE_IV[i];
        hash_state[0] ^= 32'h0101_0020 | (klen << 8);
        bytes_hashed = '0;
        clear_block();
        if (klen > 0) begin
            for (int i = 0; i < 8; i++) begin
                valid = (klen > 4 * i) ? klen - 4 * i : 0;
                block_words[i] = model_key[i / 2][32 * (i % 2) +: 32] & low_bytes(valid);
            end
            block_fill = 64;
        end
        msg_open = 1'b1;
    endfunction

    // Absorbs one accepted input beat and queues the digest after a last beat.
    function automatic void absorb_beat(input logic [31:0] data, input logic [2:0] count,
                                        input bit last, input bit kat);
        int unsigned nbytes;
        if (!msg_open)
            open_message();
        // A beat that is not last always carries four bytes; counts above four clamp.
        nbytes = (!last || count > 3'd4) ? 4 : count;
        if (nbytes > 0) begin
            // A full block is only compressed once more data shows up.
            if (block_fill >= 64) begin
                bytes_hashed += 64;
                compress_block(1'b0);
                clear_block();
            end
            block_words[block_fill / 4] = data & low_bytes(nbytes);
            block_fill += nbytes;
        end
        if (last) begin
            bytes_hashed += block_fill;
            for (int i = (block_fill + 3) / 4; i < 16; i++)
                block_words[i] = '0;
            compress_block(1'b1);
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{kat ? EMPTY_DIGEST[i] : hash_state[i], 3'(i), i == 7});
            for (int i = 0; i < 8; i++)
                hash_state[i] = '0;
            bytes_hashed = '0;
            clear_block();
            msg_open = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where the driven
    // values from the previous edge are stable.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_KEY_LENGTH)
                    model_key_len = cfg_data[5:0];
                else if (cfg_index >= CFG_KEY_LO && cfg_index <= CFG_KEY_HI)
                    model_key[cfg_index - CFG_KEY_LO] = cfg_data;
            end
            if (s_tvalid && s_tready)
                absorb_beat(s_tdata[31:0], s_tdata[34:32], s_tlast, beat_is_kat);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("digest beat with no expectation: digest_word %h", m_tdata[31:0]);
                    fail_count++;
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_tdata[31:0] !== exp_beat.digest) begin
                        $error("digest_word: expected %h, got %h", exp_beat.digest, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[34:32] !== exp_beat.index) begin
                        $error("word_index: expected %0d, got %0d", exp_beat.index,
                               m_tdata[34:32]);
                        fail_count++;
                    end
                    if (m_tlast !== exp_beat.final_word) begin
                        $error("last_word: expected %b, got %b", exp_beat.final_word, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Back-pressure on the digest side. Most stalls are short, a few are
    // long, and in burst phases the sink never stalls at all.
    // ------------------------------------------------------------------
    bit burst_mode;
    int sink_hold;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (burst_mode) begin
            m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else if ($urandom_range(99) < 8) begin
            sink_hold <= $urandom_range(40, 10);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) < 65);
        end
    end

    // Idle gap before an input beat: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (burst_mode || roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Presents one input beat and holds it until the unit takes it.
    task automatic send_word(input logic [31:0] data, input logic [2:0] count, input bit last,
                             input bit kat = 1'b0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {5'b0, count, data};
        s_tlast     <= last;
        beat_is_kat <= kat;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Waits until every digest has come back and the unit is idle again,
    // then lets it settle.
    task automatic drain_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digest_q.size() != 0 || !s_tready)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Writes the key length and all four key words back to back.
    task automatic load_key(input logic [5:0] klen, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        logic [63:0] values [5];
        logic [2:0]  regs [5];
        values = '{{58'b0, klen}, k0, k1, k2, k3};
        regs   = '{CFG_KEY_LENGTH, CFG_KEY_LO, CFG_KEY_MIDLO, CFG_KEY_MIDHI, CFG_KEY_HI};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Directed rows: one message per run of rows ending in a last beat.
    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        bit          last;
        bit          kat;
    } stim_row_t;

    stim_row_t directed_rows [] = '{
        // Empty message, no key: known digest.
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1},
        // Short count on a beat that is not last still carries four bytes.
        '{32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0},
        '{32'hA5A5_A5A5, 3'd0, 1'b0, 1'b0},
        // Count of seven on the last beat clamps to four.
        '{32'h1234_5678, 3'd7, 1'b1, 1'b0},
        // Bytes beyond the count must be ignored.
        '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0},
        '{32'hDEAD_BEEF, 3'd4, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 3'd5, 1'b1, 1'b0},
        // Empty last beat after data.
        '{32'h0000_0001, 3'd6, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b0}
    };

    // Random message: mostly short, some ending right on a block boundary,
    // a few spanning several blocks.
    task automatic send_random_message(inout int sent);
        int words;
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            words = $urandom_range(20, 1);
        else if (roll < 85)
            words = 16 * $urandom_range(2, 1) + $urandom_range(1, 0);
        else
            words = $urandom_range(48, 21);
        for (int i = 0; i < words - 1; i++)
            send_word($urandom(), 3'($urandom_range(7)), 1'b0);
        send_word($urandom(), 3'($urandom_range(7)), 1'b1);
        sent += words;
    endtask

    initial begin
        logic [5:0] klen;
        int         sent;
        int         roll;
        int         batch;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        beat_is_kat = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_KEY_LENGTH;
        cfg_data    = '0;
        burst_mode  = 1'b0;
        fail_count  = 0;
        model_key_len = '0;
        for (int i = 0; i < 4; i++)
            model_key[i] = '0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = '0;
        bytes_hashed = '0;
        clear_block();
        msg_open = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unkeyed directed rows straight out of reset.
        foreach (directed_rows[i])
            send_word(directed_rows[i].data, directed_rows[i].count, directed_rows[i].last,
                      directed_rows[i].kat);
        drain_digests();

        // Key length past the top of the range, all-ones key: clamps to 32.
        load_key(6'd63, '1, '1, '1, '1);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        drain_digests();

        // One-byte key, and then exactly 32 and 33 bytes with a random key.
        load_key(6'd1, 64'h5A, '0, '0, '0);
        send_word(32'h0, 3'd0, 1'b1);
        drain_digests();
        load_key(6'd32, rand64(), rand64(), rand64(), rand64());
        send_word(32'h0102_0304, 3'd3, 1'b1);
        drain_digests();
        load_key(6'd33, rand64(), rand64(), rand64(), rand64());
        send_word(32'h0, 3'd0, 1'b1);
        drain_digests();

        // Random part: fresh key settings every few messages, alternating
        // between phases with random idling and phases with none.
        sent = 0;
        while (sent < 170) begin
            roll = $urandom_range(99);
            if (roll < 25)
                klen = 6'd0;
            else if (roll < 40)
                klen = 6'd32;
            else
                klen = 6'($urandom_range(63));
            load_key(klen, rand64(), rand64(), rand64(), rand64());
            burst_mode = ($urandom_range(3) == 0);
            batch = $urandom_range(4, 2);
            for (int j = 0; j < batch && sent < 170; j++)
                send_random_message(sent);
            drain_digests();
        end
        burst_mode = 1'b0;
        repeat (100) @(posedge aclk);

        if (fail_count == 0)
            $display("blake2s_keyed_hash_unit regression: pass");
        else
            $display("blake2s_keyed_hash_unit regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("blake2s_keyed_hash_unit regression: fail");
        $finish;
    end

endmodule
